@@ src/ilfs_pkg.sv @@
// Shared types and constants for the chat line field splitter.
// No dependencies; used by ilfs_parse and irc_line_field_splitter.

package ilfs_pkg;

  // Parse phases.
  localparam logic [2:0] PH_SKIP = 3'd0;
  localparam logic [2:0] PH_NICK = 3'd1;
  localparam logic [2:0] PH_USER = 3'd2;
  localparam logic [2:0] PH_HOST = 3'd3;
  localparam logic [2:0] PH_CMD  = 3'd4;
  localparam logic [2:0] PH_RCPT = 3'd5;
  localparam logic [2:0] PH_MSG  = 3'd6;
  localparam logic [2:0] PH_DONE = 3'd7;

  // Field tags.
  localparam logic [2:0] TAG_NONE = 3'd0;
  localparam logic [2:0] TAG_NICK = 3'd1;
  localparam logic [2:0] TAG_USER = 3'd2;
  localparam logic [2:0] TAG_HOST = 3'd3;
  localparam logic [2:0] TAG_CMD  = 3'd4;
  localparam logic [2:0] TAG_RCPT = 3'd5;
  localparam logic [2:0] TAG_MSG  = 3'd6;
  localparam logic [2:0] TAG_IGN  = 3'd7;

  // Event kinds.
  localparam logic [2:0] EV_SERVER = 3'd0;
  localparam logic [2:0] EV_MSG    = 3'd1;
  localparam logic [2:0] EV_JOIN   = 3'd2;
  localparam logic [2:0] EV_PART   = 3'd3;
  localparam logic [2:0] EV_QUIT   = 3'd4;
  localparam logic [2:0] EV_BOT    = 3'd5;

  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [31:0] CMD_JOIN = 32'h4A4F494E;
  localparam logic [31:0] CMD_PART = 32'h50415254;
  localparam logic [31:0] CMD_QUIT = 32'h51554954;

  localparam logic [9:0] POS_MAX    = 10'd1023;
  localparam logic [9:0] POS_OUTMAX = 10'd511;
  localparam logic [4:0] CLEN_MAX   = 5'd31;
  localparam logic [4:0] CLEN_WORD  = 5'd4;

  typedef struct packed {
    logic [2:0]  phase;
    logic [9:0]  pos;
    logic [2:0]  evt;
    logic [31:0] cmd_shift;
    logic [4:0]  cmd_len;
    logic        colon_ok;
  } parse_state_t;

  typedef struct packed {
    logic [2:0] tag;
    logic [7:0] char_val;
    logic [8:0] pos;
    logic       store;
    logic [2:0] evt;
    logic       done;
  } result_t;

  localparam parse_state_t STATE_RESET = '{
    phase: PH_SKIP, pos: 10'd0, evt: EV_SERVER, cmd_shift: 32'd0, cmd_len: 5'd0,
    colon_ok: 1'b0
  };

endpackage

@@ src/irc_line_field_splitter.sv @@
// Top level of the chat line field splitter: handshake, input and result registers.
// Depends on ilfs_pkg and ilfs_parse.

// Takes one byte per cycle and returns one tagged result per byte, in order;
// throughput is one byte every clock cycle while the output does not stall.
// The input register and the result register sit around the combinational
// parse logic. A byte waits in the input register, and its result is then
// registered in the result register, where it is presented. The parser state
// advances when a byte moves from the input register into the result register.
// A stall on the output side holds the result register, and once the input
// register is full it holds that too and backs up into in_stall_o.

module irc_line_field_splitter #(
  parameter int NICK_LEN = 32,
  parameter int HOST_LEN = 64,
  parameter int CMD_LEN  = 16,
  parameter int CHAN_LEN = 64,
  parameter int MSG_LEN  = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] line_byte_i,
  input  logic       line_start_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] field_tag_o,
  output logic [7:0] char_out_o,
  output logic [8:0] char_pos_o,
  output logic       store_char_o,
  output logic [2:0] event_kind_o,
  output logic       line_done_o
);

  logic                   in_v_q;
  logic [7:0]             byte_q;
  logic                   start_q;
  logic                   out_v_q;
  ilfs_pkg::result_t      res_q;
  ilfs_pkg::result_t      res_d;
  ilfs_pkg::parse_state_t state_q;
  ilfs_pkg::parse_state_t state_d;
  logic                   adv_out;
  logic                   adv_in;
  logic                   move;

  assign adv_out = !out_v_q || !out_stall_i;
  assign adv_in  = !in_v_q || adv_out;
  assign move    = in_v_q && adv_out;

  assign in_stall_o = !adv_in;

  ilfs_parse #(
    .NICK_LEN(NICK_LEN),
    .HOST_LEN(HOST_LEN),
    .CMD_LEN (CMD_LEN),
    .CHAN_LEN(CHAN_LEN),
    .MSG_LEN (MSG_LEN)
  ) u_parse (
    .state_i     (state_q),
    .line_byte_i (byte_q),
    .line_start_i(start_q),
    .state_o     (state_d),
    .result_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      state_q <= ilfs_pkg::STATE_RESET;
    end else begin
      if (adv_in) begin
        in_v_q <= in_valid_i;
      end
      if (adv_out) begin
        out_v_q <= in_v_q;
      end
      if (move) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && in_valid_i) begin
      byte_q  <= line_byte_i;
      start_q <= line_start_i;
    end
    if (move) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_v_q;
  assign field_tag_o  = res_q.tag;
  assign char_out_o   = res_q.char_val;
  assign char_pos_o   = res_q.pos;
  assign store_char_o = res_q.store;
  assign event_kind_o = res_q.evt;
  assign line_done_o  = res_q.done;

endmodule

@@ src/ilfs_parse.sv @@
// Per-byte parse logic: next parser state and the tagged result for one byte.
// Depends on ilfs_pkg.

module ilfs_parse #(
  parameter int NICK_LEN = 32,
  parameter int HOST_LEN = 64,
  parameter int CMD_LEN  = 16,
  parameter int CHAN_LEN = 64,
  parameter int MSG_LEN  = 512
) (
  input  ilfs_pkg::parse_state_t state_i,
  input  logic [7:0]             line_byte_i,
  input  logic                   line_start_i,
  output ilfs_pkg::parse_state_t state_o,
  output ilfs_pkg::result_t      result_o
);

  localparam logic [9:0] NickLim = 10'(NICK_LEN - 1);
  localparam logic [9:0] HostLim = 10'(HOST_LEN);
  localparam logic [9:0] CmdLim  = 10'(CMD_LEN - 1);
  localparam logic [9:0] ChanLim = 10'(CHAN_LEN - 1);
  localparam logic [9:0] MsgLim  = 10'(MSG_LEN - 3);

  ilfs_pkg::parse_state_t st;
  ilfs_pkg::parse_state_t nx;
  ilfs_pkg::result_t      res;
  logic                   eol;
  logic                   done;
  logic                   emit;
  logic [9:0]             limit;
  logic [2:0]             emit_tag;
  logic [2:0]             cmd_evt;

  always_comb begin
    st  = line_start_i ? ilfs_pkg::STATE_RESET : state_i;
    eol = (line_byte_i == ilfs_pkg::CH_CR) || (line_byte_i == ilfs_pkg::CH_LF);
    nx  = st;
    done     = 1'b0;
    emit     = 1'b0;
    limit    = NickLim;
    emit_tag = ilfs_pkg::TAG_NONE;

    // Exact match on the command, valid only for a four-byte command.
    cmd_evt = st.evt;
    if (st.cmd_len == ilfs_pkg::CLEN_WORD) begin
      if (st.cmd_shift == ilfs_pkg::CMD_JOIN) begin
        cmd_evt = ilfs_pkg::EV_JOIN;
      end else if (st.cmd_shift == ilfs_pkg::CMD_PART) begin
        cmd_evt = ilfs_pkg::EV_PART;
      end else if (st.cmd_shift == ilfs_pkg::CMD_QUIT) begin
        cmd_evt = ilfs_pkg::EV_QUIT;
      end
    end

    res.tag      = ilfs_pkg::TAG_NONE;
    res.char_val = line_byte_i;
    res.pos      = 9'd0;
    res.store    = 1'b0;

    case (st.phase)
      ilfs_pkg::PH_SKIP: begin
        nx.phase = ilfs_pkg::PH_NICK;
        nx.pos = 10'd0;
        nx.colon_ok = 1'b0;
      end
      ilfs_pkg::PH_NICK: begin
        if (eol || line_byte_i == ilfs_pkg::CH_SPACE) begin
          done = 1'b1;
        end else if (line_byte_i == ilfs_pkg::CH_BANG) begin
          nx.evt = ilfs_pkg::EV_MSG;
          nx.phase = ilfs_pkg::PH_USER;
          nx.pos = 10'd0;
          nx.colon_ok = 1'b0;
        end else begin
          emit = 1'b1;
          emit_tag = ilfs_pkg::TAG_NICK;
          limit = NickLim;
        end
      end
      ilfs_pkg::PH_USER: begin
        if (eol) begin
          done = 1'b1;
        end else if (line_byte_i == ilfs_pkg::CH_AT) begin
          nx.phase = ilfs_pkg::PH_HOST;
          nx.pos = 10'd0;
          nx.colon_ok = 1'b0;
        end else begin
          emit = 1'b1;
          emit_tag = ilfs_pkg::TAG_USER;
          limit = NickLim;
        end
      end
      ilfs_pkg::PH_HOST: begin
        if (eol) begin
          done = 1'b1;
        end else if (line_byte_i == ilfs_pkg::CH_SPACE) begin
          nx.phase = ilfs_pkg::PH_CMD;
          nx.pos = 10'd0;
          nx.colon_ok = 1'b0;
        end else begin
          emit = 1'b1;
          emit_tag = ilfs_pkg::TAG_HOST;
          limit = HostLim;
        end
      end
      ilfs_pkg::PH_CMD: begin
        if (eol || line_byte_i == ilfs_pkg::CH_SPACE) begin
          nx.evt = cmd_evt;
          if (eol) begin
            done = 1'b1;
          end else begin
            nx.phase = ilfs_pkg::PH_RCPT;
            nx.pos = 10'd0;
            nx.colon_ok = 1'b1;
          end
        end else begin
          nx.cmd_shift = {st.cmd_shift[23:0], line_byte_i};
          if (st.cmd_len < ilfs_pkg::CLEN_MAX) begin
            nx.cmd_len = st.cmd_len + 5'd1;
          end
          emit = 1'b1;
          emit_tag = ilfs_pkg::TAG_CMD;
          limit = CmdLim;
        end
      end
      ilfs_pkg::PH_RCPT: begin
        if (eol) begin
          done = 1'b1;
        end else if (line_byte_i == ilfs_pkg::CH_SPACE) begin
          nx.phase = ilfs_pkg::PH_MSG;
          nx.pos = 10'd0;
          nx.colon_ok = 1'b1;
        end else if (st.colon_ok && line_byte_i == ilfs_pkg::CH_COLON) begin
          nx.colon_ok = 1'b0;
        end else begin
          nx.colon_ok = 1'b0;
          emit = 1'b1;
          emit_tag = ilfs_pkg::TAG_RCPT;
          limit = ChanLim;
        end
      end
      ilfs_pkg::PH_MSG: begin
        if (eol) begin
          done = 1'b1;
        end else if (st.colon_ok && line_byte_i == ilfs_pkg::CH_COLON) begin
          nx.colon_ok = 1'b0;
        end else begin
          nx.colon_ok = 1'b0;
          // A message whose first byte is a bang is a bot command.
          if (st.pos == 10'd0 && line_byte_i == ilfs_pkg::CH_BANG) begin
            nx.evt = ilfs_pkg::EV_BOT;
          end
          emit = 1'b1;
          emit_tag = ilfs_pkg::TAG_MSG;
          limit = MsgLim;
        end
      end
      default: begin
        res.tag = ilfs_pkg::TAG_IGN;
      end
    endcase

    if (emit) begin
      res.tag   = emit_tag;
      res.pos   = (st.pos > ilfs_pkg::POS_OUTMAX) ? 9'd511 : st.pos[8:0];
      res.store = (st.pos < limit);
      if (st.pos < ilfs_pkg::POS_MAX) begin
        nx.pos = st.pos + 10'd1;
      end
    end

    if (done) begin
      res.tag = ilfs_pkg::TAG_NONE;
      res.pos = 9'd0;
      res.store = 1'b0;
      nx.phase = ilfs_pkg::PH_DONE;
      nx.pos = 10'd0;
      nx.colon_ok = 1'b0;
    end

    res.evt  = nx.evt;
    res.done = done;
    state_o  = nx;
    result_o = res;
  end

endmodule
